/* src/fwrm_pkg.sv */
// Shared types and constants for the FIFO with running maximum.
// Used by fwrm_ctrl, fwrm_dp and the fifo_with_running_max top level.
`timescale 1ns / 1ps
`default_nettype none

package fwrm_pkg;

  // Storage geometry.
  localparam int CAPACITY = 16;
  localparam int PTR_W    = $clog2(CAPACITY);
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;
  localparam int MAX_W    = 31;

  // Action codes of an input item.
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Status codes of a result item.
  localparam logic [1:0] STATUS_DONE       = 2'd0;
  localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
  localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

  // Input item.
  typedef struct packed {
    logic                     action;
    logic signed [VAL_W-1:0]  value;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] entry_count;
    logic [MAX_W-1:0] largest;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;   // accept the input item and apply it
    logic check;  // compare the popped entry against the maximum
    logic scan;   // rescan step
    logic load;   // load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_check;  // the item pops and leaves entries behind
    logic match;       // the popped entry equals the maximum
    logic scan_done;   // every remaining entry has been compared
    logic out_free;    // the result register can take a new item
  } sts_t;

endpackage

`default_nettype wire

/* src/fwrm_ctrl.sv */
// Controller state machine for the FIFO with running maximum.
// Depends on fwrm_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module fwrm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire fwrm_pkg::sts_t sts,
  output fwrm_pkg::cmd_t     cmd,
  output logic               in_stall
);
  import fwrm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_CHECK  = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.need_check ? ST_CHECK : ST_FINISH;
        end
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = sts.match ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Items are taken only between operations.
  assign in_stall = (state_r != ST_IDLE);

endmodule

`default_nettype wire

/* src/fwrm_dp.sv */
// Datapath for the FIFO with running maximum: entry memory, pointers,
// count, maximum, rescan counters and result register. Depends on fwrm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fwrm_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fwrm_pkg::cmd_t     cmd,
  input  wire fwrm_pkg::in_item_t in_data,
  input  wire logic               out_stall,
  output fwrm_pkg::sts_t          sts,
  output logic                    out_valid,
  output fwrm_pkg::out_item_t     out_data
);
  import fwrm_pkg::*;

  logic [VAL_W-1:0] mem [CAPACITY];
  logic [VAL_W-1:0] rd_data_r;

  logic [PTR_W-1:0] newest_r, newest_nxt;
  logic [PTR_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [MAX_W-1:0] max_r, max_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [PTR_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0] scan_left_r, scan_left_nxt;
  logic             rd_pend_r, rd_pend_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic             we;
  logic             re;
  logic [PTR_W-1:0] raddr;
  logic             is_pop;
  logic             full;
  logic             empty;
  logic             scan_issue;

  function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign is_pop     = (in_data.action == ACT_POP);
  assign full       = (count_r == CNT_W'(CAPACITY));
  assign empty      = (count_r == '0);
  assign scan_issue = cmd.scan && (scan_left_r != '0);

  // Entry memory: one write port, one registered read port.
  assign we    = cmd.take && !is_pop && !full;
  assign re    = (cmd.take && is_pop && !empty) || scan_issue;
  assign raddr = cmd.scan ? scan_ptr_r : oldest_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[newest_r] <= in_data.value;
    end
    if (re) begin
      rd_data_r <= mem[raddr];
    end
  end

  // Status toward the controller.
  assign sts.need_check = is_pop && (count_r > CNT_W'(1));
  assign sts.match      = (rd_data_r == {1'b0, max_r});
  assign sts.scan_done  = (scan_left_r == '0) && !rd_pend_r;
  assign sts.out_free   = !out_valid_r || !out_stall;

  // Next-state logic for the FIFO state and the rescan.
  always_comb begin
    newest_nxt    = newest_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    max_nxt       = max_r;
    status_nxt    = status_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_left_nxt = scan_left_r;
    rd_pend_nxt   = 1'b0;

    if (cmd.take) begin
      status_nxt = STATUS_DONE;
      if (!is_pop) begin
        if (full) begin
          status_nxt = STATUS_PUSH_FULL;
        end else begin
          newest_nxt = advance(newest_r);
          count_nxt  = count_r + CNT_W'(1);
          // A non-negative value at least the maximum replaces it.
          if (!in_data.value[VAL_W-1] && (in_data.value[MAX_W-1:0] >= max_r)) begin
            max_nxt = in_data.value[MAX_W-1:0];
          end
        end
      end else begin
        if (empty) begin
          status_nxt = STATUS_POP_EMPTY;
        end else begin
          oldest_nxt = advance(oldest_r);
          count_nxt  = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            max_nxt = '0;
          end
        end
      end
    end

    // The popped entry was the maximum: restart it at zero and rescan.
    if (cmd.check && sts.match) begin
      max_nxt       = '0;
      scan_ptr_nxt  = oldest_r;
      scan_left_nxt = count_r;
    end

    // Rescan: issue one read a cycle, compare the returned data in the next cycle.
    if (scan_issue) begin
      scan_ptr_nxt  = advance(scan_ptr_r);
      scan_left_nxt = scan_left_r - CNT_W'(1);
      rd_pend_nxt   = 1'b1;
    end
    if (cmd.scan && rd_pend_r) begin
      if (!rd_data_r[VAL_W-1] && (rd_data_r[MAX_W-1:0] > max_r)) begin
        max_nxt = rd_data_r[MAX_W-1:0];
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      newest_r    <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      max_r       <= '0;
      status_r    <= STATUS_DONE;
      scan_ptr_r  <= '0;
      scan_left_r <= '0;
      rd_pend_r   <= 1'b0;
    end else begin
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      status_r    <= status_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      scan_left_r <= scan_left_nxt;
      rd_pend_r   <= rd_pend_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r.status      <= status_r;
      out_data_r.entry_count <= count_r;
      out_data_r.largest     <= max_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* src/fifo_with_running_max.sv */
// Top level of the FIFO with running maximum: controller plus datapath.
// Depends on fwrm_pkg, fwrm_ctrl and fwrm_dp.
//
//   Port group   Direction   Payload            Flow control
//   in_*         input       in_item_t          in_valid / in_stall
//   out_*        output      out_item_t         out_valid / out_stall
//
// A push, a rejected item or a pop of the last entry is applied in ST_IDLE and
// its result is loaded into the result register in ST_FINISH. Any other pop adds
// ST_CHECK to compare the popped entry with the maximum; when it was the maximum,
// ST_SCAN rescans the n remaining entries through the single read port. Reset
// clears pointers, count and maximum; the entry memory is not cleared. A stalled
// result holds in the output register while the next item is taken and applied;
// that item's result waits to load.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_running_max (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire fwrm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output fwrm_pkg::out_item_t      out_data
);
  import fwrm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing of each item.
  fwrm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Storage, maximum tracking and result register.
  fwrm_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
